FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the slot table RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, suspended while reset is high
`define ST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included
`define ST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/stwe_pkg.sv
// Package for the slot table with expiry: request/response structs, kind codes
// and configuration register indexes. No dependencies.
`default_nettype none

package stwe_pkg;

   // Default sizing
   localparam int SLOTS_DEF    = 16;
   localparam int KEY_BITS_DEF = 64;

   // Fixed field widths
   localparam int KIND_W   = 3;
   localparam int KEY_W    = 64;
   localparam int INDEX_W  = 4;
   localparam int FREED_W  = 5;
   localparam int SIU_W    = 5;
   localparam int TTL_W    = 31;
   localparam int TIME_W   = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_ENTER = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LEAVE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TOUCH = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SWEEP = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TICK  = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TTL_TICKS    = 4'd1;

   // Register reset values
   localparam logic [SIU_W-1:0] SIU_RESET = 5'd16;
   localparam logic [TTL_W-1:0] TTL_RESET = 31'd60;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [INDEX_W-1:0] slot_index;
      logic [FREED_W-1:0] freed_count;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/slot_table_with_expiry.sv
// Slot table with expiry: session admission table kept in two synchronous RAMs.
// Depends on stwe_pkg and assert_macros.svh.
//
// One request is taken when start is high and busy is low; busy then stays high
// while the entries are scanned through the single read port of the key and
// stamp RAMs, one entry per cycle. Enter, leave and touch stop at the first
// matching entry; sweep visits every entry in use. With n = min(slots_in_use,
// SLOTS) entries considered, a request reads at most n entries (tick, unused
// kinds and zero-key leave/touch read none). The response is
// driven with rsp_valid for exactly one cycle, the cycle after busy falls, and
// must be captured then: the receiver cannot stall the block. Occupancy is held
// in per-slot flip-flops cleared by reset, so no clearing pass is needed.
// Configuration writes are taken whenever busy is low.
`default_nettype none
`include "assert_macros.svh"

module slot_table_with_expiry #(
   parameter int SLOTS    = stwe_pkg::SLOTS_DEF,
   parameter int KEY_BITS = stwe_pkg::KEY_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request transaction
   input  wire logic                                start,
   output logic                                     busy,
   input  wire stwe_pkg::req_type                   req_data,
   // Response transaction
   output logic                                     rsp_valid,
   output stwe_pkg::rsp_type                        rsp_data,
   // Configuration write
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [stwe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [stwe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS = $clog2(SLOTS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // Control and configuration state
   logic                              state_ff, state_in;
   logic [stwe_pkg::SIU_W-1:0]        siu_ff;
   logic [stwe_pkg::TTL_W-1:0]        ttl_ff;
   logic [stwe_pkg::TIME_W-1:0]       time_ff;
   logic [stwe_pkg::KIND_W-1:0]       kind_ff;
   logic [KEY_BITS-1:0]               key_ff;
   logic [CNT_BITS-1:0]               n_ff, n_in;
   logic [CNT_BITS-1:0]               cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]               freed_ff, freed_in;
   logic                              p_vld_ff, p_vld_in;
   logic [IDX_BITS-1:0]               p_idx_ff, p_idx_in;
   logic [SLOTS-1:0]                  valid_ff;
   logic                              rsp_valid_ff;
   stwe_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   // Storage
   logic [KEY_BITS-1:0]               key_mem_ff   [SLOTS];
   logic [stwe_pkg::TIME_W-1:0]       stamp_mem_ff [SLOTS];
   logic [KEY_BITS-1:0]               rd_key_ff;
   logic [stwe_pkg::TIME_W-1:0]       rd_stamp_ff;

   logic                              accept;
   logic                              csr_we;
   logic [CNT_BITS-1:0]               n_act;
   logic                              rd_en;
   logic [IDX_BITS-1:0]               rd_addr;
   logic                              cur_valid;
   logic                              key_eq;
   logic [stwe_pkg::TIME_W-1:0]       age;
   logic                              expired;
   logic                              hit;
   logic                              sweep_free;
   logic                              finish;
   logic                              key_we;
   logic                              stamp_we;
   logic [IDX_BITS+stwe_pkg::INDEX_W-1:0] idx_wide;
   logic [CNT_BITS+stwe_pkg::FREED_W-1:0] freed_wide;

   assign busy      = (state_ff == ST_SCAN);
   assign accept    = start && !busy;
   assign csr_ready = !busy;
   assign csr_we    = csr_valid && csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Slots considered, clamped to the table size
   always_comb begin
      if ({{(32-stwe_pkg::SIU_W){1'b0}}, siu_ff} > 32'(SLOTS)) begin
         n_act = CNT_BITS'(SLOTS);
      end else begin
         n_act = CNT_BITS'(siu_ff);
      end
   end

   // Compare stage on the registered read data
   assign cur_valid  = valid_ff[p_idx_ff];
   assign key_eq     = (rd_key_ff == key_ff);
   assign age        = time_ff - rd_stamp_ff;
   assign expired    = cur_valid && (age > {1'b0, ttl_ff});
   assign sweep_free = p_vld_ff && (kind_ff == stwe_pkg::KIND_SWEEP) && expired;

   always_comb begin
      case (kind_ff)
         stwe_pkg::KIND_ENTER: hit = p_vld_ff && !cur_valid;
         stwe_pkg::KIND_LEAVE,
         stwe_pkg::KIND_TOUCH: hit = p_vld_ff && cur_valid && key_eq;
         default:              hit = 1'b0;
      endcase
   end

   assign finish   = busy && (hit || ((cnt_ff == n_ff) && !p_vld_ff));
   assign rd_en    = busy && !hit && (cnt_ff != n_ff);
   assign rd_addr  = cnt_ff[IDX_BITS-1:0];
   assign key_we   = hit && (kind_ff == stwe_pkg::KIND_ENTER);
   assign stamp_we = hit && ((kind_ff == stwe_pkg::KIND_ENTER) ||
                             (kind_ff == stwe_pkg::KIND_TOUCH));

   assign idx_wide   = {{stwe_pkg::INDEX_W{1'b0}}, p_idx_ff};
   assign freed_wide = {{stwe_pkg::FREED_W{1'b0}}, freed_ff};

   // Sequencer next state
   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      cnt_in      = cnt_ff;
      freed_in    = freed_ff;
      p_vld_in    = rd_en;
      p_idx_in    = rd_addr;
      rsp_data_in = rsp_data_ff;
      if (accept) begin
         state_in = ST_SCAN;
         cnt_in   = '0;
         freed_in = '0;
         p_vld_in = 1'b0;
         case (req_data.kind)
            stwe_pkg::KIND_ENTER,
            stwe_pkg::KIND_SWEEP: n_in = n_act;
            stwe_pkg::KIND_LEAVE,
            stwe_pkg::KIND_TOUCH: n_in = (req_data.key[KEY_BITS-1:0] != '0) ? n_act : '0;
            default:              n_in = '0;
         endcase
      end else if (busy) begin
         if (rd_en) begin
            cnt_in = cnt_ff + 1'b1;
         end
         if (sweep_free) begin
            freed_in = freed_ff + 1'b1;
         end
         if (finish) begin
            state_in                = ST_IDLE;
            p_vld_in                = 1'b0;
            rsp_data_in.ok          = hit;
            rsp_data_in.slot_index  = hit ? idx_wide[stwe_pkg::INDEX_W-1:0] : '0;
            rsp_data_in.freed_count = freed_wide[stwe_pkg::FREED_W-1:0];
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         siu_ff       <= stwe_pkg::SIU_RESET;
         ttl_ff       <= stwe_pkg::TTL_RESET;
         time_ff      <= '0;
         n_ff         <= '0;
         cnt_ff       <= '0;
         freed_ff     <= '0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         cnt_ff       <= cnt_in;
         freed_ff     <= freed_in;
         p_vld_ff     <= p_vld_in;
         rsp_valid_ff <= finish;
         if (accept && (req_data.kind == stwe_pkg::KIND_TICK)) begin
            time_ff <= time_ff + 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               stwe_pkg::CSR_SLOTS_IN_USE: siu_ff <= csr_wdata[stwe_pkg::SIU_W-1:0];
               stwe_pkg::CSR_TTL_TICKS:    ttl_ff <= csr_wdata[stwe_pkg::TTL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      p_idx_ff    <= p_idx_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         kind_ff <= req_data.kind;
         key_ff  <= req_data.key[KEY_BITS-1:0];
      end
   end

   // Occupancy bits: set by a non-zero enter, cleared by leave and sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (key_we && (key_ff != '0)) begin
            valid_ff[p_idx_ff] <= 1'b1;
         end
         if ((hit && (kind_ff == stwe_pkg::KIND_LEAVE)) || sweep_free) begin
            valid_ff[p_idx_ff] <= 1'b0;
         end
      end
   end

   // Key and stamp RAMs, one registered read port
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[p_idx_ff] <= key_ff;
      end
      if (stamp_we) begin
         stamp_mem_ff[p_idx_ff] <= time_ff;
      end
      if (rd_en) begin
         rd_key_ff   <= key_mem_ff[rd_addr];
         rd_stamp_ff <= stamp_mem_ff[rd_addr];
      end
   end

   // Checks
   `ST_ASSERT(a_rsp_when_idle, rsp_valid |-> !busy, "response strobe while busy")
   `ST_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
   `ST_ASSERT(a_inflight_busy, p_vld_ff |-> busy, "read in flight while idle")
   `ST_ASSERT(a_scan_bound, cnt_ff <= n_ff, "scan ran past slots in use")
   `ST_ASSERT(a_freed_bound, freed_ff <= n_ff || !busy, "freed more slots than scanned")

endmodule

`default_nettype wire
